// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- sv/dq_pkg.sv -----
`default_nettype none

package dq_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_REPORT     = 3'd4;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [4:0]  count;
      logic        is_empty;
      logic        is_full;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [IDX_W-1:0]     waddr;
      logic [WORD_BITS-1:0] wdata;
      logic                 re;
      logic [IDX_W-1:0]     raddr;
   } ram_req_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RD_F  = 4'b0010,
      S_RD_B  = 4'b0100,
      S_CAP   = 4'b1000
   } state_type;

   // a + b folded into 0..DEPTH-1, for a < DEPTH and b <= DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
      if (s >= (CNT_W + 1)'(DEPTH)) begin
         s = s - (CNT_W + 1)'(DEPTH);
      end
      return IDX_W'(s);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] r;
      if (a == '0) begin
         r = IDX_W'(DEPTH - 1);
      end else begin
         r = a - IDX_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/dq_ram.sv -----
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // hold the last word read while re is low
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/dq_seq.sv -----
`default_nettype none
`include "assert_macros.svh"

module dq_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dq_pkg::req_type                 req_data,
   input  logic                            out_free,
   output logic                            done,
   output dq_pkg::rsp_type                 result,
   output dq_pkg::ram_req_type             ram_req,
   input  logic [dq_pkg::WORD_BITS-1:0]    ram_rdata
);

   import dq_pkg::*;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           status_ff, status_in;
   logic [WORD_BITS-1:0] front_ff, front_in;
   logic                 accept;
   logic                 full;
   logic                 empty;
   logic [CNT_W-1:0]     back_off;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign back_off  = empty ? '0 : count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      front_in      = front_ff;
      done          = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.waddr = head_ff;
      ram_req.wdata = WORD_BITS'(req_data.value);
      ram_req.re    = 1'b0;
      ram_req.raddr = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_DONE;
               case (req_data.kind)
                  KIND_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        head_in       = ring_prev(head_ff);
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ring_prev(head_ff);
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ring_add(head_ff, count_ff);
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (empty) begin
                        status_in = ST_UNDERFLOW;
                     end else begin
                        head_in  = ring_add(head_ff, CNT_W'(1));
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  KIND_POP_BACK: begin
                     if (empty) begin
                        status_in = ST_UNDERFLOW;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
               state_in = S_RD_F;
            end
         end
         S_RD_F: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = head_ff;
            state_in      = S_RD_B;
         end
         S_RD_B: begin
            front_in      = ram_rdata;
            ram_req.re    = 1'b1;
            ram_req.raddr = ring_add(head_ff, back_off);
            state_in      = S_CAP;
         end
         S_CAP: begin
            // back word sits in the read register until the output frees up
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.front_value = empty ? 32'd0 : 32'(front_ff);
      result.back_value  = empty ? 32'd0 : 32'(ram_rdata);
      result.count       = 5'(count_ff);
      result.is_empty    = empty;
      result.is_full     = full;
      result.status      = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      status_ff <= status_in;
      front_ff  <= front_in;
   end

   `ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_NXT(a_accept_reads, clock, reset, accept, state_ff == S_RD_F)
   `ASSERT_IMP(a_write_on_accept, clock, reset, ram_req.we, accept && status_in == ST_DONE)

endmodule

`default_nettype wire

// ----- sv/double_ended_queue_top.sv -----
// Bounded deque of 32-bit words in a ring held in one single-port-read RAM.
// Each item is accepted, then its front and back words are read serially
// from the RAM and the result register is loaded, which waits while the
// result register is stalled; no new item is accepted until then.
// Reset (synchronous, active high) empties the deque; RAM contents are kept.
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output dq_pkg::rsp_type rsp_data
);

   import dq_pkg::*;

   ram_req_type          ram_req;
   logic [WORD_BITS-1:0] ram_rdata;
   logic                 out_free;
   logic                 seq_done;
   rsp_type              seq_result;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   dq_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   dq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .done      (seq_done),
      .result    (seq_result),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = seq_done;
         // load a new item, or drop the one just taken
         if (seq_done) begin
            rsp_data_in = seq_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMP(a_no_overwrite, clock, reset, seq_done, !(rsp_valid_ff && rsp_stall))
   `ASSERT_IMP(a_busy_while_holding, clock, reset, rsp_valid_ff && rsp_stall, req_stall || !seq_done)

endmodule

`default_nettype wire
